>>> hw/rtl/vole_machine_core_defines.svh
// Assertion macros shared by the vole machine RTL.
// Include with the bare file name; needs nothing else.
`ifndef VOLE_MACHINE_CORE_DEFINES_SVH
`define VOLE_MACHINE_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define VM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet during reset
`define VM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/vm_pkg.sv
// Shared types and constants for the vole machine core.
// No dependencies; imported by vm_seq and vole_machine_core.
`timescale 1ns / 1ps
`default_nettype none

package vm_pkg;

  localparam int DATA_W        = 8;
  localparam int IW_W          = 16;
  localparam int NUM_REGS      = 16;
  localparam int REG_AW        = 4;
  localparam int MEM_CELLS_DEF = 256;

  // Host transaction kinds (s_tuser)
  typedef enum logic [1:0] {
    HOP_WRITE     = 2'd0,
    HOP_EXEC      = 2'd1,
    HOP_READ_CELL = 2'd2,
    HOP_READ_REG  = 2'd3
  } hop_t;

  // Instruction opcodes (top nibble of the instruction word)
  localparam logic [3:0] IOP_LOAD  = 4'h1;
  localparam logic [3:0] IOP_LDI   = 4'h2;
  localparam logic [3:0] IOP_STORE = 4'h3;
  localparam logic [3:0] IOP_MOVE  = 4'h4;
  localparam logic [3:0] IOP_ADD   = 4'h5;
  localparam logic [3:0] IOP_HALT  = 4'hC;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HRD,
    S_F1,
    S_F2,
    S_OPA,
    S_OPB,
    S_DONE
  } st_t;

  // Cell store port request
  typedef struct packed {
    logic              we;
    logic [7:0]        waddr;
    logic [DATA_W-1:0] wdata;
    logic [7:0]        raddr;
  } mem_req_t;

  // Register file port request
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [REG_AW-1:0] raddr;
  } reg_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/vm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/vm_seq.sv
// Vole machine sequencer: host transactions, fetch/decode/execute, valid bits,
// output register. Depends on vm_pkg and vole_machine_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "vole_machine_core_defines.svh"

module vm_seq #(
  parameter int MEM_CELLS = vm_pkg::MEM_CELLS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [15:0]               s_tdata,
  input  wire logic [1:0]                s_tuser,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [47:0]                    m_tdata,
  output logic [0:0]                     m_tuser,
  output vm_pkg::mem_req_t               mem_req,
  input  wire logic [vm_pkg::DATA_W-1:0] mem_rdata,
  output vm_pkg::reg_req_t               reg_req,
  input  wire logic [vm_pkg::DATA_W-1:0] reg_rdata
);

  import vm_pkg::*;

  localparam int         MAW      = $clog2(MEM_CELLS);
  localparam logic [8:0] CELL_LIM = 9'(MEM_CELLS);

  st_t                 state, state_next;
  logic [7:0]          pc;
  logic [IW_W-1:0]     instr;
  logic                halt_flag;
  hop_t                op_q;
  logic [7:0]          addr_q;
  logic [DATA_W-1:0]   hi_q, opa_q, rd_q, pval_q;
  logic                pv_q;
  logic [MEM_CELLS-1:0] cvalid;
  logic [NUM_REGS-1:0] rvalid;
  logic                cvld_q, rvld_q;
  logic [DATA_W-1:0]   mem_val, reg_val;
  logic [IW_W-1:0]     iw_next;
  hop_t                in_op;
  logic [7:0]          in_addr;
  logic [DATA_W-1:0]   in_data;
  logic                rd_ok, wr_ok, out_load;

  assign in_op   = hop_t'(s_tuser);
  assign in_addr = s_tdata[7:0];
  assign in_data = s_tdata[15:8];

  // Cells never written and cells outside the store read as zero
  assign mem_val  = cvld_q ? mem_rdata : '0;
  assign reg_val  = rvld_q ? reg_rdata : '0;
  assign iw_next  = {hi_q, mem_val};
  assign rd_ok    = {1'b0, mem_req.raddr} < CELL_LIM;
  assign wr_ok    = {1'b0, mem_req.waddr} < CELL_LIM;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Next state and memory port requests
  always_comb begin
    state_next = state;
    mem_req    = '0;
    reg_req    = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (in_op)
            HOP_WRITE: begin
              mem_req.we    = ({1'b0, in_addr} < CELL_LIM);
              mem_req.waddr = in_addr;
              mem_req.wdata = in_data;
              state_next    = S_DONE;
            end
            HOP_EXEC: begin
              mem_req.raddr = pc;
              state_next    = halt_flag ? S_DONE : S_F1;
            end
            HOP_READ_CELL: begin
              mem_req.raddr = in_addr;
              state_next    = S_HRD;
            end
            default: begin
              reg_req.raddr = in_addr[REG_AW-1:0];
              state_next    = S_HRD;
            end
          endcase
        end
      end
      S_HRD: state_next = S_DONE;
      S_F1: begin
        mem_req.raddr = pc + 8'd1;
        state_next    = S_F2;
      end
      S_F2: begin
        // Issue the operand read of the freshly fetched instruction
        case (iw_next[15:12])
          IOP_LOAD: begin
            mem_req.raddr = iw_next[7:0];
            state_next    = S_OPA;
          end
          IOP_LDI: begin
            // Immediate loads write the register file straight from decode
            reg_req.we    = 1'b1;
            reg_req.waddr = iw_next[11:8];
            reg_req.wdata = iw_next[7:0];
            state_next    = S_DONE;
          end
          IOP_STORE: begin
            reg_req.raddr = iw_next[11:8];
            state_next    = S_OPA;
          end
          IOP_MOVE, IOP_ADD: begin
            reg_req.raddr = iw_next[7:4];
            state_next    = S_OPA;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_OPA: begin
        state_next = S_DONE;
        case (instr[15:12])
          IOP_LOAD: begin
            reg_req.we    = 1'b1;
            reg_req.waddr = instr[11:8];
            reg_req.wdata = mem_val;
          end
          IOP_STORE: begin
            mem_req.waddr = instr[7:0];
            mem_req.wdata = reg_val;
            mem_req.we    = (instr[7:0] != 8'd0) && wr_ok;
          end
          IOP_MOVE: begin
            reg_req.we    = 1'b1;
            reg_req.waddr = instr[3:0];
            reg_req.wdata = reg_val;
          end
          IOP_ADD: begin
            reg_req.raddr = instr[3:0];
            state_next    = S_OPB;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_OPB: begin
        reg_req.we    = 1'b1;
        reg_req.waddr = instr[11:8];
        reg_req.wdata = opa_q + reg_val;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      instr     <= '0;
      halt_flag <= 1'b0;
      m_tvalid  <= 1'b0;
      cvalid    <= '0;
      rvalid    <= '0;
    end else begin
      state <= state_next;
      if (mem_req.we) begin
        cvalid[mem_req.waddr[MAW-1:0]] <= 1'b1;
      end
      if (reg_req.we) begin
        rvalid[reg_req.waddr] <= 1'b1;
      end
      if (state == S_F2) begin
        instr <= iw_next;
        pc    <= pc + 8'd2;
        if (iw_next[15:12] == IOP_HALT) begin
          halt_flag <= 1'b1;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: read-valid tags, operands, result fields
  always_ff @(posedge clk) begin
    cvld_q <= rd_ok && cvalid[mem_req.raddr[MAW-1:0]];
    rvld_q <= rvalid[reg_req.raddr];
    case (state)
      S_IDLE: begin
        op_q   <= in_op;
        addr_q <= in_addr;
        rd_q   <= '0;
        pv_q   <= 1'b0;
        pval_q <= '0;
      end
      S_HRD: begin
        if (op_q == HOP_READ_CELL) begin
          rd_q <= mem_val;
        end else begin
          rd_q <= (addr_q[7:REG_AW] == '0) ? reg_val : '0;
        end
      end
      S_F1: hi_q <= mem_val;
      S_OPA: begin
        if (instr[15:12] == IOP_STORE && instr[7:0] == 8'd0) begin
          pv_q   <= 1'b1;
          pval_q <= reg_val;
        end
        opa_q <= reg_val;
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {7'd0, instr, pc, halt_flag, pval_q, rd_q};
      m_tuser <= pv_q;
    end
  end

  `VM_ASSERT_NEXT(a_halt_sticky, clk, rst, halt_flag, halt_flag, "halt flag cleared")
  `VM_ASSERT_NEXT(a_pc_hold, clk, rst, state != S_F2, pc == $past(pc), "pc moved outside fetch")
  `VM_ASSERT_NOW(a_one_write, clk, rst, mem_req.we, !reg_req.we, "cell and register written together")
  `VM_ASSERT_NEXT(a_out_load, clk, rst, out_load, m_tvalid && state == S_IDLE, "result not posted")

endmodule

`default_nettype wire

>>> hw/rtl/vole_machine_core.sv
// Top level of the vole machine: cell store RAM, register file RAM, sequencer.
// Depends on vm_pkg, vm_ram and vm_seq.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata: address, data; s_tuser: opcode
//  m_       out  m_tvalid/m_tready    m_tdata: results; m_tuser: print_valid
//
// A host write or halted execute goes from accept to S_DONE, a host read via
// S_HRD, an executed instruction via S_F1, S_F2, S_OPA and S_OPB as needed
// (two fetch reads through the single cell-store read port, then up to two
// register-file reads for an add). s_tready rises with m_tvalid of the result.
// rst is synchronous; all cells and registers read as zero after it, no sweep.
// A stalled result holds the next transaction in the final state until taken.
`timescale 1ns / 1ps
`default_nettype none

module vole_machine_core #(
  parameter int MEM_CELLS = vm_pkg::MEM_CELLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // address[7:0], data[15:8]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // read_data[7:0], print_value[15:8],
                                      // halted[16], program_counter[24:17],
                                      // instruction_word[40:25], zero[47:41]
  output logic [0:0]       m_tuser    // print_valid[0]
);

  import vm_pkg::*;

  localparam int MAW = $clog2(MEM_CELLS);

  mem_req_t          mem_req;
  reg_req_t          reg_req;
  logic [DATA_W-1:0] mem_rdata, reg_rdata;

  // Cell store
  vm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr[MAW-1:0]),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr[MAW-1:0]),
    .rdata (mem_rdata)
  );

  // Register file
  vm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk   (clk),
    .we    (reg_req.we),
    .waddr (reg_req.waddr),
    .wdata (reg_req.wdata),
    .raddr (reg_req.raddr),
    .rdata (reg_rdata)
  );

  // Sequencer
  vm_seq #(
    .MEM_CELLS (MEM_CELLS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .reg_req   (reg_req),
    .reg_rdata (reg_rdata)
  );

endmodule

`default_nettype wire

>>> verif/tb_vole_machine_core.sv
`timescale 1ns / 1ps
// Self-checking bench for vole_machine_core: streams host transactions into the core,
// predicts each result in a small scoreboard class and compares the output stream.
// Depends on vm_pkg and the vole_machine_core RTL.

module tb_vole_machine_core;
  import vm_pkg::*;

  localparam int N_ITEMS    = 850;
  localparam int QUIET_FROM = 720;   // no idling on either side from here on
  localparam int LONG_HOLD  = 250;   // receiver hold-off, in cycles

  // One expected output transaction
  typedef struct {
    logic [7:0]  read_data;
    logic        print_valid;
    logic [7:0]  print_value;
    logic        halted;
    logic [7:0]  pc;
    logic [15:0] instr_word;
  } vole_result_t;

  // Machine state tracker and result checker
  class vole_tracker;
    logic [7:0]   cells [256];
    logic [7:0]   regs [NUM_REGS];
    logic [7:0]   pc;
    logic [15:0]  instr;
    logic         halt_seen;
    vole_result_t outstanding [$];
    int           errors;
    int           n_exec;
    int           n_print;
    int           n_read;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      foreach (regs[i]) regs[i] = 8'h00;
      pc = 8'h00;
      instr = 16'h0000;
      halt_seen = 1'b0;
      errors = 0;
      n_exec = 0;
      n_print = 0;
      n_read = 0;
    endfunction

    // Apply one accepted input transaction and queue the result it must produce
    function void note_request(hop_t op, logic [7:0] addr, logic [7:0] data);
      vole_result_t r;
      logic [3:0]   rr, ss, tt;
      logic [7:0]   xy;
      r.read_data = 8'h00;
      r.print_valid = 1'b0;
      r.print_value = 8'h00;
      case (op)
        HOP_WRITE: cells[addr] = data;
        HOP_EXEC: begin
          if (!halt_seen) begin
            n_exec++;
            // fetch two bytes, pc wraps at 256
            instr = {cells[pc], cells[pc + 8'd1]};
            pc = pc + 8'd2;
            rr = instr[11:8];
            ss = instr[7:4];
            tt = instr[3:0];
            xy = instr[7:0];
            case (instr[15:12])
              IOP_LOAD:  regs[rr] = cells[xy];
              IOP_LDI:   regs[rr] = xy;
              IOP_STORE: begin
                if (xy == 8'h00) begin
                  r.print_valid = 1'b1;
                  r.print_value = regs[rr];
                  n_print++;
                end else begin
                  cells[xy] = regs[rr];
                end
              end
              IOP_MOVE:  regs[tt] = regs[ss];
              IOP_ADD:   regs[rr] = regs[ss] + regs[tt];
              IOP_HALT:  halt_seen = 1'b1;
              default: ;
            endcase
          end
        end
        HOP_READ_CELL: begin
          r.read_data = cells[addr];
          n_read++;
        end
        default: begin
          // register index past the file reads as zero
          if (addr < NUM_REGS) r.read_data = regs[addr[3:0]];
          n_read++;
        end
      endcase
      r.halted = halt_seen;
      r.pc = pc;
      r.instr_word = instr;
      outstanding.insert(outstanding.size(), r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    // Check one accepted output transaction against the oldest expectation
    function void check_response(logic [47:0] tdata, logic [0:0] tuser);
      vole_result_t w;
      if (outstanding.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %h", tdata, tuser);
        errors++;
        return;
      end
      w = outstanding.pop_front();
      compare("read_data", 16'(w.read_data), 16'(tdata[7:0]));
      compare("print_valid", 16'(w.print_valid), 16'(tuser[0]));
      compare("print_value", 16'(w.print_value), 16'(tdata[15:8]));
      compare("halted", 16'(w.halted), 16'(tdata[16]));
      compare("program_counter", 16'(w.pc), 16'(tdata[24:17]));
      compare("instruction_word", w.instr_word, tdata[40:25]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;   // address[7:0], data[15:8]
  logic [1:0]  s_tuser = HOP_WRITE;  // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;              // read_data, print_value, halted, pc, instr word
  logic [0:0]  m_tuser;              // print_valid

  vole_tracker book;
  int          n_sent = 0;
  bit          calm = 1'b0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;

  vole_machine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offer one input transaction, wait for acceptance, then maybe go idle
  task automatic send_item(hop_t op, logic [7:0] addr, logic [7:0] data);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {data, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_request(op, addr, data);
    n_sent++;
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Place an instruction at the current pc and execute it
  task automatic run_step(logic [15:0] word);
    send_item(HOP_WRITE, book.pc, word[15:8]);
    send_item(HOP_WRITE, book.pc + 8'd1, word[7:0]);
    send_item(HOP_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.outstanding.size() != 0) @(posedge clk);
  endtask

  // Random instruction, weighted toward the defined opcodes, never a halt
  function automatic logic [15:0] random_instr();
    logic [3:0]  op;
    logic [11:0] rest;
    rest = 12'($urandom);
    case ($urandom_range(0, 9))
      0, 1: op = IOP_LOAD;
      2, 3: op = IOP_LDI;
      4, 5: begin
        op = IOP_STORE;
        if ($urandom_range(0, 4) == 0) rest[7:0] = 8'h00;
      end
      6: op = IOP_MOVE;
      7, 8: op = IOP_ADD;
      default: begin
        op = 4'($urandom_range(0, 15));
        while ((op >= IOP_LOAD && op <= IOP_ADD) || op == IOP_HALT)
          op = 4'($urandom_range(0, 15));
      end
    endcase
    return {op, rest};
  endfunction

  // Output side: check results, random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) book.check_response(m_tdata, m_tuser);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int blk;
    blk = 0;
    book = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: out-of-range register reads, top cell, each instruction kind but halt
    send_item(HOP_READ_REG, 8'd16, 8'h00);
    send_item(HOP_READ_REG, 8'hFF, 8'hFF);
    send_item(HOP_READ_CELL, 8'hFF, 8'h00);
    run_step({IOP_LDI, 4'h1, 8'hFF});
    run_step({IOP_LDI, 4'h2, 8'h01});
    run_step({IOP_ADD, 4'h3, 4'h1, 4'h2});   // FF + 01 wraps to 00
    run_step({IOP_MOVE, 4'h0, 4'h3, 4'h4});
    run_step({IOP_STORE, 4'h1, 8'h00});      // store to 00 prints
    run_step({IOP_STORE, 4'h1, 8'hFF});
    run_step({IOP_LOAD, 4'h5, 8'hFF});
    run_step(16'hA5C3);                      // undefined opcode: fetch only
    send_item(HOP_READ_REG, 8'd5, 8'h00);

    // Random: mostly programmed steps, the rest host writes, reads and bare executes
    while (n_sent < N_ITEMS - 6) begin
      blk++;
      if (blk % 25 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      calm = (n_sent >= QUIET_FROM);
      if (blk == 90) hold_req = 1'b1;
      if (blk == 180) wait_drained();
      if ($urandom_range(0, 3) != 0) begin
        run_step(random_instr());
      end else begin
        case ($urandom_range(0, 4))
          0: send_item(HOP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          1: send_item(HOP_READ_CELL, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
          2: send_item(HOP_READ_REG, 8'($urandom_range(0, 19)), 8'($urandom_range(0, 255)));
          3: send_item(HOP_READ_REG, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          default: begin
            // stale memory is fine to run, as long as it is not a halt
            if (book.cells[book.pc][7:4] != IOP_HALT)
              send_item(HOP_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end

    // Halt last: afterwards executes change nothing
    calm = 1'b1;
    run_step({IOP_HALT, 12'h000});
    send_item(HOP_EXEC, 8'h00, 8'h00);
    send_item(HOP_WRITE, book.pc, {IOP_LDI, 4'h0});
    send_item(HOP_EXEC, 8'hFF, 8'hFF);
    send_item(HOP_READ_REG, 8'($urandom_range(0, 15)), 8'h00);

    wait_drained();
    repeat (12) @(posedge clk);
    $display("Covered %0d transactions: %0d executed steps, %0d prints, %0d host reads.",
             n_sent, book.n_exec, book.n_print, book.n_read);
    $display("Included a long output hold-off, a full drain pause and execution after halt.");
    if (book.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
